FILE: sv/rpb_pkg.sv
`timescale 1ns / 1ps

package rpb_pkg;

	// Default framebuffer geometry
	localparam int unsigned SCREEN_W_DEF = 512;
	localparam int unsigned SCREEN_H_DEF = 512;

	// Field widths
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned POS_W   = 16;
	localparam int unsigned PIX_W   = 16;
	localparam int unsigned LVL_W   = 8;
	localparam int unsigned IDX_W   = 18;
	localparam int unsigned RB_W    = 5;
	localparam int unsigned G_W     = 6;
	localparam int unsigned FACT_W  = LVL_W + 1;

	// Factor that passes a channel through the x/256 scaler unchanged
	localparam logic [FACT_W-1:0] FACT_UNITY = FACT_W'(256);

	typedef enum logic [CMD_W-1:0] {
		CMD_FADE   = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_BRIGHT = 2'd2,
		CMD_SOFT   = 2'd3
	} cmd_t;

endpackage

FILE: sv/rgb565_pixel_blend_unit.sv
`timescale 1ns / 1ps

// Channel   Ports                                                   Handshake
// input     cmd pos_x pos_y old_pixel src_color level sprite_alpha  start, busy
// result    new_pixel pixel_index write_enable                      valid (1-cycle strobe)
//
// Three register stages: inputs, bounds and weight (s1); channel multiply and
// index add (s2); saturating add and output register (s3).
// An accepted transaction's result passes the s1, s2 and s3 registers before it reaches the outputs.
// One transaction per clock; busy stays low, since nothing downstream can stall.
// arst_n clears the stage valid bits only; payload registers are not reset.
module rgb565_pixel_blend_unit
	import rpb_pkg::*;
#(
	parameter int unsigned SCREEN_W = SCREEN_W_DEF,
	parameter int unsigned SCREEN_H = SCREEN_H_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic [PIX_W-1:0]        old_pixel,
	input  logic [PIX_W-1:0]        src_color,
	input  logic [LVL_W-1:0]        level,
	input  logic [LVL_W-1:0]        sprite_alpha,
	output logic                    valid,
	output logic [PIX_W-1:0]        new_pixel,
	output logic [IDX_W-1:0]        pixel_index,
	output logic                    write_enable
);

	localparam logic [POS_W-2:0] W_LIM = (POS_W-1)'(SCREEN_W);
	localparam logic [POS_W-2:0] H_LIM = (POS_W-1)'(SCREEN_H);
	localparam logic [IDX_W-1:0] W_IDX = IDX_W'(SCREEN_W);

	// Stage 1
	logic               valid_s1;
	cmd_t               cmd_s1;
	logic               in_bounds_s1;
	logic [PIX_W-1:0]   old_s1;
	logic [PIX_W-1:0]   src_s1;
	logic [LVL_W-1:0]   level_s1;
	logic               alpha_zero_s1;
	logic [LVL_W-1:0]   w_s1;
	logic [IDX_W-1:0]   yprod_s1;
	logic [IDX_W-1:0]   x_s1;

	// Stage 2
	logic               valid_s2;
	logic [PIX_W-1:0]   old_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic               we_s2;
	logic               add_s2;

	// Stage 3
	logic               valid_s3;
	logic [PIX_W-1:0]   pixel_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic               we_s3;

	logic                  accept;
	logic                  in_x;
	logic                  in_y;
	logic [2*LVL_W-1:0]    wprod;
	logic [IDX_W-1:0]      y_ext;
	logic [FACT_W-1:0]     factor;
	logic [PIX_W-1:0]      opnd;
	logic                  we_c;
	logic [RB_W-1:0]       r_res;
	logic [G_W-1:0]        g_res;
	logic [RB_W-1:0]       b_res;
	logic [PIX_W-1:0]      blended;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign in_x  = !pos_x[POS_W-1] && (pos_x[POS_W-2:0] < W_LIM);
	assign in_y  = !pos_y[POS_W-1] && (pos_y[POS_W-2:0] < H_LIM);
	assign wprod = (2*LVL_W)'(sprite_alpha) * (2*LVL_W)'(level);
	assign y_ext = IDX_W'(pos_y[POS_W-2:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1        <= cmd_t'(cmd);
		in_bounds_s1  <= in_x && in_y;
		old_s1        <= old_pixel;
		src_s1        <= src_color;
		level_s1      <= level;
		alpha_zero_s1 <= (sprite_alpha == '0);
		w_s1          <= wprod[2*LVL_W-1:LVL_W];
		yprod_s1      <= IDX_W'(y_ext * W_IDX);
		x_s1          <= IDX_W'(pos_x[POS_W-2:0]);
	end

	// Pick the scaled operand, factor and write enable per operation; plain add scales by unity
	always_comb begin
		unique case (cmd_s1)
			CMD_FADE: begin
				factor = {1'b0, level_s1};
				opnd   = old_s1;
				we_c   = in_bounds_s1 && (old_s1 != '0);
			end
			CMD_ADD: begin
				factor = FACT_UNITY;
				opnd   = src_s1;
				we_c   = in_bounds_s1;
			end
			CMD_BRIGHT: begin
				factor = {1'b0, level_s1};
				opnd   = src_s1;
				we_c   = in_bounds_s1;
			end
			CMD_SOFT: begin
				factor = {1'b0, w_s1};
				opnd   = src_s1;
				we_c   = in_bounds_s1 && !alpha_zero_s1 && (w_s1 != '0);
			end
			default: begin
				factor = FACT_UNITY;
				opnd   = src_s1;
				we_c   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		old_s2 <= old_s1;
		idx_s2 <= in_bounds_s1 ? (yprod_s1 + x_s1) : '0;
		we_s2  <= we_c;
		add_s2 <= (cmd_s1 != CMD_FADE);
	end

	rpb_lane #(.CW(RB_W)) u_lane_r (
		.clk    (clk),
		.opnd   (opnd[PIX_W-1 -: RB_W]),
		.factor (factor),
		.base   (old_s2[PIX_W-1 -: RB_W]),
		.add_en (add_s2),
		.res    (r_res)
	);

	rpb_lane #(.CW(G_W)) u_lane_g (
		.clk    (clk),
		.opnd   (opnd[RB_W +: G_W]),
		.factor (factor),
		.base   (old_s2[RB_W +: G_W]),
		.add_en (add_s2),
		.res    (g_res)
	);

	rpb_lane #(.CW(RB_W)) u_lane_b (
		.clk    (clk),
		.opnd   (opnd[RB_W-1:0]),
		.factor (factor),
		.base   (old_s2[RB_W-1:0]),
		.add_en (add_s2),
		.res    (b_res)
	);

	assign blended = {r_res, g_res, b_res};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Skipped writes keep the old pixel (fade of black is zero either way)
	always_ff @(posedge clk) begin
		pixel_s3 <= we_s2 ? blended : old_s2;
		idx_s3   <= idx_s2;
		we_s3    <= we_s2;
	end

	assign valid        = valid_s3;
	assign new_pixel    = pixel_s3;
	assign pixel_index  = idx_s3;
	assign write_enable = we_s3;

endmodule

FILE: sv/rpb_lane.sv
`timescale 1ns / 1ps

// One color channel: scale by factor/256 in stage 2, saturating add onto base (when add_en) in stage 3.
module rpb_lane
	import rpb_pkg::*;
#(
	parameter int unsigned CW = RB_W
) (
	input  logic              clk,
	input  logic [CW-1:0]     opnd,
	input  logic [FACT_W-1:0] factor,
	input  logic [CW-1:0]     base,
	input  logic              add_en,
	output logic [CW-1:0]     res
);

	logic [CW+FACT_W-1:0] prod;
	logic [CW-1:0]        scaled_s2;
	logic [CW:0]          sum;

	assign prod = (CW+FACT_W)'(opnd) * (CW+FACT_W)'(factor);

	always_ff @(posedge clk) begin
		scaled_s2 <= prod[CW+7:8];
	end

	assign sum = {1'b0, base} + {1'b0, scaled_s2};

	// Clamp at the channel's full-scale value
	always_comb begin
		if (!add_en) begin
			res = scaled_s2;
		end else if (sum[CW]) begin
			res = '1;
		end else begin
			res = sum[CW-1:0];
		end
	end

endmodule

FILE: sv/rpb_checker.sv
`timescale 1ns / 1ps

module rpb_checker
	import rpb_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic [CMD_W-1:0]        cmd,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic [PIX_W-1:0]        old_pixel,
	input logic                    valid,
	input logic [PIX_W-1:0]        new_pixel,
	input logic [IDX_W-1:0]        pixel_index,
	input logic                    write_enable
);

	// Every accepted transaction yields a result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 valid)
		else $error("result strobe missing three cycles after accept");

	// No result strobe without an earlier accepted transaction
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(start && !busy, 3))
		else $error("result strobe without accepted transaction");

	// Negative coordinates never write and report index zero
	a_oob: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (pos_x[POS_W-1] || pos_y[POS_W-1])
		|-> ##3 (!write_enable && pixel_index == '0))
		else $error("out-of-bounds pixel written or indexed");

	// Fade of a black pixel skips the write and leaves black
	a_fade_black: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd == CMD_FADE && old_pixel == '0
		|-> ##3 (!write_enable && new_pixel == '0))
		else $error("fade of black pixel mishandled");

endmodule

bind rgb565_pixel_blend_unit rpb_checker u_rpb_checker (.*);
